[hw/rtl/teleop_frame_decoder_core_macros.svh]
// Assertion helpers shared by the frame decoder RTL.
`ifndef TELEOP_FRAME_DECODER_CORE_MACROS_SVH
`define TELEOP_FRAME_DECODER_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TFD_ASSERT_IMM(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TFD_ASSERT_IMM(lbl, ante, cons, msg)
`define TFD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/tfd_pkg.sv]
package tfd_pkg;

  localparam int FRAME_BYTES = 12;
  localparam int WIN_KEEP    = FRAME_BYTES - 1;
  localparam int FILL_W      = $clog2(FRAME_BYTES);

  localparam logic [7:0] HDR0 = 8'h66;
  localparam logic [7:0] HDR1 = 8'hCC;

  localparam int BTN_A_POS = 5;
  localparam int BTN_B_POS = 6;
  localparam int THR_POS   = 8;
  localparam int STR_POS   = 9;

  // button bit positions (active low)
  localparam int BA_MODE  = 4;
  localparam int BA_ESTOP = 6;
  localparam int BA_LEFT  = 7;
  localparam int BA_RIGHT = 5;
  localparam int BB_HB    = 2;
  localparam int BB_GEAR  = 0;

  // toggle flag bit positions
  localparam int TF_MODE  = 0;
  localparam int TF_LEFT  = 1;
  localparam int TF_RIGHT = 2;
  localparam int TF_HB    = 3;
  localparam int TF_GEAR  = 4;
  localparam int TF_W     = 5;

  localparam logic [7:0] AXIS_CENTER = 8'd128;
  localparam logic [7:0] AXIS_LO     = 8'd125;
  localparam logic [7:0] AXIS_HI     = 8'd130;

  localparam int CMD_W   = 15;
  localparam int STEER_W = 16;

  localparam int CFG_ADDR_W = 2;
  localparam logic [7:0] STEER_GAIN_RST = 8'd200;
  localparam logic [7:0] BRAKE_GAIN_RST = 8'd40;
  localparam logic [7:0] SPEED_GAIN_RST = 8'd15;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_STEER_GAIN = 2'd0,
    REG_BRAKE_GAIN = 2'd1,
    REG_SPEED_GAIN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] steer;
    logic [7:0] brake;
    logic [7:0] speed;
  } gains_t;

  typedef struct packed {
    logic [7:0] btn_a;
    logic [7:0] btn_b;
    logic [7:0] thr;
    logic [7:0] str;
  } frame_t;

  // packed so that the first field lands in the highest bits
  typedef struct packed {
    logic signed [STEER_W-1:0] steer_cmd;
    logic [CMD_W-1:0]          brake_cmd;
    logic [CMD_W-1:0]          speed_cmd;
    logic                      emergency_stop;
    logic                      drive_gear;
    logic                      hand_brake_on;
    logic                      right_lamp;
    logic                      left_lamp;
    logic                      auto_mode;
  } result_t;

endpackage

[hw/rtl/tfd_window.sv]
`include "teleop_frame_decoder_core_macros.svh"

module tfd_window (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic [7:0]      in_byte,
  input  logic            take,
  output logic            hit_v,
  output tfd_pkg::frame_t hit_frame
);
  import tfd_pkg::*;

  logic [7:0]        line_r [WIN_KEEP];
  logic [FILL_W-1:0] fill_r;
  logic              hit_v_r;
  frame_t            hit_frame_r;
  logic [7:0]        sum;
  logic              full;
  logic              frame_ok;

  always_comb begin
    sum = 8'd0;
    for (int i = 0; i < WIN_KEEP; i++) begin
      sum = sum + line_r[i];
    end
  end

  assign full     = (fill_r == FILL_W'(WIN_KEEP));
  assign frame_ok = full && (line_r[0] == HDR0) && (line_r[1] == HDR1) && (sum == in_byte);

  // shift line: oldest byte at index 0, every accepted byte shifts in
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < WIN_KEEP - 1; i++) begin
        line_r[i] <= line_r[i+1];
      end
      line_r[WIN_KEEP-1] <= in_byte;
    end
    if (in_fire && frame_ok) begin
      hit_frame_r.btn_a <= line_r[BTN_A_POS];
      hit_frame_r.btn_b <= line_r[BTN_B_POS];
      hit_frame_r.thr   <= line_r[THR_POS];
      hit_frame_r.str   <= line_r[STR_POS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      hit_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (full) begin
          fill_r <= frame_ok ? '0 : FILL_W'(WIN_KEEP);
        end else begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (in_fire) begin
        hit_v_r <= frame_ok;
      end else if (take) begin
        hit_v_r <= 1'b0;
      end
    end
  end

  assign hit_v     = hit_v_r;
  assign hit_frame = hit_frame_r;

  `TFD_ASSERT_NXT(a_hit_source, !hit_v_r && !(in_fire && full), !hit_v_r,
                  "frame hit without a full window")
  `TFD_ASSERT_NXT(a_fill_wrap, in_fire && full,
                  fill_r == '0 || fill_r == FILL_W'(WIN_KEEP),
                  "fill count left the full window badly")
endmodule

[hw/rtl/tfd_decode.sv]
`include "teleop_frame_decoder_core_macros.svh"

module tfd_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             hit_v,
  input  tfd_pkg::frame_t  hit_frame,
  input  tfd_pkg::gains_t  gains,
  input  logic             out_ready,
  output logic             take,
  output logic             out_v,
  output tfd_pkg::result_t result
);
  import tfd_pkg::*;

  logic                      out_v_r;
  logic [TF_W-1:0]           flags_r;
  logic [TF_W-1:0]           flags_nxt;
  logic [7:0]                prev_a_r;
  logic [7:0]                prev_b_r;
  logic [CMD_W-1:0]          held_speed_r;
  logic [CMD_W-1:0]          held_brake_r;
  logic [CMD_W-1:0]          held_speed_nxt;
  logic [CMD_W-1:0]          held_brake_nxt;
  logic                      estop_r;
  logic signed [STEER_W-1:0] steer_r;
  logic signed [STEER_W-1:0] steer_nxt;
  logic                      fire;
  logic [7:0]                a;
  logic [7:0]                b;
  logic signed [8:0]         steer_dev;
  logic signed [17:0]        steer_prod;
  logic [7:0]                spd_dev;
  logic [7:0]                brk_dev;
  logic [15:0]               spd_prod;
  logic [15:0]               brk_prod;

  assign take = !out_v_r || out_ready;
  assign fire = hit_v && take;
  assign a    = hit_frame.btn_a;
  assign b    = hit_frame.btn_b;

  // press: low now, high in the previous frame
  always_comb begin
    flags_nxt = flags_r;
    flags_nxt[TF_MODE]  = flags_r[TF_MODE]  ^ (!a[BA_MODE]  && prev_a_r[BA_MODE]);
    flags_nxt[TF_LEFT]  = flags_r[TF_LEFT]  ^ (!a[BA_LEFT]  && prev_a_r[BA_LEFT]);
    flags_nxt[TF_RIGHT] = flags_r[TF_RIGHT] ^ (!a[BA_RIGHT] && prev_a_r[BA_RIGHT]);
    if (!b[BB_HB] && prev_b_r[BB_HB]) begin
      flags_nxt[TF_HB] = !flags_r[TF_HB];
    end else if (b[BB_HB] && !flags_r[TF_HB] && !b[BB_GEAR] && prev_b_r[BB_GEAR]) begin
      flags_nxt[TF_GEAR] = !flags_r[TF_GEAR];
    end
  end

  assign steer_dev  = $signed({1'b0, AXIS_CENTER}) - $signed({1'b0, hit_frame.str});
  assign steer_prod = steer_dev * $signed({1'b0, gains.steer});
  assign steer_nxt  = (hit_frame.str > AXIS_LO && hit_frame.str < AXIS_HI) ?
                      '0 : steer_prod[STEER_W-1:0];

  assign spd_dev  = AXIS_CENTER - hit_frame.thr;
  assign brk_dev  = hit_frame.thr - AXIS_CENTER;
  assign spd_prod = spd_dev * gains.speed;
  assign brk_prod = brk_dev * gains.brake;

  always_comb begin
    held_speed_nxt = held_speed_r;
    held_brake_nxt = held_brake_r;
    if (!flags_nxt[TF_HB] && flags_nxt[TF_GEAR]) begin
      if (hit_frame.thr >= AXIS_HI) begin
        held_brake_nxt = brk_prod[CMD_W-1:0];
        held_speed_nxt = '0;
      end else if (hit_frame.thr <= AXIS_LO) begin
        held_speed_nxt = spd_prod[CMD_W-1:0];
        held_brake_nxt = '0;
      end else begin
        held_speed_nxt = '0;
        held_brake_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r      <= 1'b0;
      flags_r      <= '0;
      prev_a_r     <= 8'hFF;
      prev_b_r     <= 8'hFF;
      held_speed_r <= '0;
      held_brake_r <= '0;
    end else begin
      if (fire) begin
        out_v_r      <= 1'b1;
        flags_r      <= flags_nxt;
        prev_a_r     <= a;
        prev_b_r     <= b;
        held_speed_r <= held_speed_nxt;
        held_brake_r <= held_brake_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      estop_r <= !a[BA_ESTOP];
      steer_r <= steer_nxt;
    end
  end

  assign out_v                 = out_v_r;
  assign result.auto_mode      = flags_r[TF_MODE];
  assign result.left_lamp      = flags_r[TF_LEFT];
  assign result.right_lamp     = flags_r[TF_RIGHT];
  assign result.hand_brake_on  = flags_r[TF_HB];
  assign result.drive_gear     = flags_r[TF_GEAR];
  assign result.emergency_stop = estop_r;
  assign result.speed_cmd      = held_speed_r;
  assign result.brake_cmd      = held_brake_r;
  assign result.steer_cmd      = steer_r;

  `TFD_ASSERT_NXT(a_stall_hold, out_v_r && !out_ready,
                  $stable(flags_r) && $stable(held_speed_r) && $stable(held_brake_r),
                  "decoder state moved while result stalled")
  `TFD_ASSERT_IMM(a_gear_lock, fire && flags_r[TF_HB],
                  flags_nxt[TF_GEAR] == flags_r[TF_GEAR],
                  "gear toggled with hand brake on")
endmodule

[hw/rtl/teleop_frame_decoder_core.sv]
// Remote-control frame decoder.
// in_*  : one received serial byte per beat (in_tdata[7:0]).
// out_* : one beat per accepted 12-byte frame carrying mode, lights, hand
//         brake, gear, emergency stop and the speed/brake/steer commands
//         in 1/128 units.
// cfg_* : write-only gains (steer, brake, speed); write only while idle.
// Bytes enter a sliding window; when the eleven held bytes plus the new one
// start with 0x66 0xCC and carry a matching 8-bit checksum, the window
// restarts empty and the frame is decoded.
// After the last frame byte is accepted, the result beat passes the window
// check register, then the decode/output register.
// The window takes one byte per cycle while in_tready is high; the checksum
// adder in the window stage is combinational.
// Reset clears the window fill, the toggles (all off), the held speed and
// brake (zero), the previous buttons (all released) and the gains to
// 200/40/15. When the receiver stalls, the result holds and one more frame
// can wait in the window stage; in_tready drops only when both are full.
module teleop_frame_decoder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] auto_mode, [1] left_lamp, [2] right_lamp, [3] hand_brake_on,
  // [4] drive_gear, [5] emergency_stop, [20:6] speed_cmd, [35:21] brake_cmd,
  // [51:36] steer_cmd, [55:52] zero
  output logic [55:0]                     out_tdata,
  input  logic                            cfg_we,
  input  logic [tfd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [7:0]                      cfg_wdata
);
  import tfd_pkg::*;

  gains_t  gains_r;
  logic    in_fire;
  logic    take;
  logic    hit_v;
  frame_t  hit_frame;
  result_t result;

  // gain registers; user writes only while the block is idle, unchecked here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.steer <= STEER_GAIN_RST;
      gains_r.brake <= BRAKE_GAIN_RST;
      gains_r.speed <= SPEED_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_STEER_GAIN: gains_r.steer <= cfg_wdata;
        REG_BRAKE_GAIN: gains_r.brake <= cfg_wdata;
        REG_SPEED_GAIN: gains_r.speed <= cfg_wdata;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // accept a byte unless a matched frame waits and cannot advance
  assign in_tready = !hit_v || take;
  assign in_fire   = in_tvalid && in_tready;

  tfd_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .take      (take),
    .hit_v     (hit_v),
    .hit_frame (hit_frame)
  );

  tfd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .hit_v     (hit_v),
    .hit_frame (hit_frame),
    .gains     (gains_r),
    .out_ready (out_tready),
    .take      (take),
    .out_v     (out_tvalid),
    .result    (result)
  );

  assign out_tdata = {4'b0000, result};
endmodule
